// ----- hdl/bdhe_pkg.sv -----
// Shared types and constants for the button debounce and hold event block.
`timescale 1ns / 1ps

package bdhe_pkg;

  // Button lanes built, width of the per-button fields, and selector ranges
  localparam int BUTTONS  = 8;
  localparam int FIELD_W  = 8;
  localparam int CONTROLS = 2;
  localparam int TUNINGS  = 8;

  localparam int CNT_W   = 16;
  localparam int CTRL_W  = 4;
  localparam int PRIOR_W = 5;
  localparam int TUNE_W  = 4;
  localparam int BTN_W   = 4;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Buttons with a role beyond debouncing
  localparam int KEY_PREV = 0;
  localparam int KEY_NEXT = 1;
  localparam int KEY_A    = 2;
  localparam int KEY_B    = 3;

  // Button value reported when no event is recorded
  localparam logic signed [BTN_W-1:0] BTN_NONE = -BTN_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE      = 3'd0,
    KIND_HOLD_CONT = 3'd1,
    KIND_HOLD_INST = 3'd2,
    KIND_PRESS     = 3'd3,
    KIND_RELEASE   = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_HOLD_TH   = 2'd1,
    CFG_HOLD_LIM  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_threshold;
    logic [CNT_W-1:0] hold_threshold;
    logic [CNT_W-1:0] hold_limit;
  } cfg_t;

  // Events of one button for one item; kind is the last one recorded
  typedef struct packed {
    logic  press;
    logic  release_ev;
    logic  hold_inst;
    logic  hold_cont;
    kind_t kind;
  } lane_evt_t;

  // Per-item status from the selector logic
  typedef struct packed {
    logic clear;
    logic tuned;
  } sel_stat_t;

endpackage

// ----- hdl/bdhe_lane.sv -----
// One button lane: mismatch and hold counters, clean level and events.
`timescale 1ns / 1ps

module bdhe_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               raw,
  input  bdhe_pkg::cfg_t     cfg,
  output bdhe_pkg::lane_evt_t evt,
  output logic               clean
);

  logic                         accepted;
  logic [bdhe_pkg::CNT_W-1:0]   mismatch;
  logic [bdhe_pkg::CNT_W-1:0]   hold;
  logic [bdhe_pkg::CNT_W-1:0]   mismatch_inc;
  logic [bdhe_pkg::CNT_W-1:0]   hold_inc;
  logic                         flip;

  always_comb begin
    mismatch_inc = mismatch;
    if (raw != accepted && mismatch != '1) begin
      mismatch_inc = mismatch + 1'b1;
    end
    hold_inc = hold;
    if (hold < cfg.hold_limit) begin
      hold_inc = hold + 1'b1;
    end
    flip = !(mismatch_inc < cfg.debounce_threshold);

    evt.hold_cont  = clean;
    evt.hold_inst  = !flip && (hold_inc >= cfg.hold_threshold) && clean;
    evt.press      = flip && raw;
    evt.release_ev = flip && !raw;
    if (flip) begin
      evt.kind = raw ? bdhe_pkg::KIND_PRESS : bdhe_pkg::KIND_RELEASE;
    end else if (evt.hold_inst) begin
      evt.kind = bdhe_pkg::KIND_HOLD_INST;
    end else if (clean) begin
      evt.kind = bdhe_pkg::KIND_HOLD_CONT;
    end else begin
      evt.kind = bdhe_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted <= 1'b0;
      clean    <= 1'b0;
      mismatch <= '0;
      hold     <= '0;
    end else if (adv) begin
      if (flip) begin
        accepted <= raw;
        clean    <= raw;
        mismatch <= '0;
        hold     <= '0;
      end else begin
        mismatch <= mismatch_inc;
        hold     <= hold_inc;
      end
    end
  end

endmodule

// ----- hdl/bdhe_select.sv -----
// Control and tuning selection, loading mark and last-event registers.
`timescale 1ns / 1ps

module bdhe_select (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  bdhe_pkg::lane_evt_t                  evt [bdhe_pkg::FIELD_W],
  output logic [bdhe_pkg::CTRL_W-1:0]          control_index,
  output logic [bdhe_pkg::PRIOR_W-1:0]         prior_control_index,
  output logic [bdhe_pkg::TUNE_W-1:0]          tuning_index,
  output logic                                 loading_flag,
  output logic signed [bdhe_pkg::BTN_W-1:0]    last_button,
  output bdhe_pkg::kind_t                      last_kind,
  output bdhe_pkg::sel_stat_t                  stat
);

  logic [bdhe_pkg::CTRL_W-1:0]        control_next;
  logic [bdhe_pkg::PRIOR_W-1:0]       prior_next;
  logic [bdhe_pkg::TUNE_W-1:0]        tuning_next;
  logic                               loading_next;
  logic signed [bdhe_pkg::BTN_W-1:0]  last_button_next;
  bdhe_pkg::kind_t                    last_kind_next;

  always_comb begin
    control_next     = control_index;
    prior_next       = prior_control_index;
    tuning_next      = tuning_index;
    loading_next     = loading_flag;
    last_button_next = last_button;
    last_kind_next   = last_kind;
    stat.clear       = 1'b0;
    stat.tuned       = 1'b0;

    // Latest button with any event wins
    for (int i = 0; i < bdhe_pkg::FIELD_W; i++) begin
      if (evt[i].kind != bdhe_pkg::KIND_NONE) begin
        last_button_next = bdhe_pkg::BTN_W'(i);
        last_kind_next   = evt[i].kind;
      end
    end

    if (evt[bdhe_pkg::KEY_PREV].press) begin
      prior_next   = bdhe_pkg::PRIOR_W'(control_index);
      control_next = (control_index == '0) ? bdhe_pkg::CTRL_W'(bdhe_pkg::CONTROLS - 1)
                                           : control_index - 1'b1;
      stat.clear   = 1'b1;
    end else if (evt[bdhe_pkg::KEY_NEXT].press) begin
      prior_next   = bdhe_pkg::PRIOR_W'(control_index);
      control_next = (control_index >= bdhe_pkg::CTRL_W'(bdhe_pkg::CONTROLS - 1)) ? '0
                                           : control_index + 1'b1;
      stat.clear   = 1'b1;
    end

    if (stat.clear) begin
      loading_next     = 1'b1;
      last_button_next = bdhe_pkg::BTN_NONE;
      last_kind_next   = bdhe_pkg::KIND_NONE;
    end else begin
      if (evt[bdhe_pkg::KEY_A].press) begin
        tuning_next = (tuning_next == '0) ? bdhe_pkg::TUNE_W'(bdhe_pkg::TUNINGS - 1)
                                          : tuning_next - 1'b1;
        stat.tuned  = 1'b1;
      end
      if (evt[bdhe_pkg::KEY_B].press) begin
        tuning_next = (tuning_next >= bdhe_pkg::TUNE_W'(bdhe_pkg::TUNINGS - 1)) ? '0
                                          : tuning_next + 1'b1;
        stat.tuned  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_index       <= '0;
      prior_control_index <= bdhe_pkg::PRIOR_W'(bdhe_pkg::CONTROLS);
      tuning_index        <= '0;
      loading_flag        <= 1'b0;
      last_button         <= bdhe_pkg::BTN_NONE;
      last_kind           <= bdhe_pkg::KIND_NONE;
    end else if (adv) begin
      control_index       <= control_next;
      prior_control_index <= prior_next;
      tuning_index        <= tuning_next;
      loading_flag        <= loading_next;
      last_button         <= last_button_next;
      last_kind           <= last_kind_next;
    end
  end

endmodule

// ----- hdl/button_debounce_hold_events_top.sv -----
// Top level of the button debouncer with hold events and control/tuning selection.
`timescale 1ns / 1ps

// Each input item is one scan tick of raw button levels; each tick yields
// exactly one result item. An item is registered on acceptance and processed
// when it advances out of the holding register, which it does once the result
// register is free or being taken; then the per-button counters, the clean
// levels and the selector registers update together and the event masks load
// into the result register, which raises out_valid. One item is taken every
// cycle as long as the result side keeps up (the result register frees as it
// is taken). The per-button mismatch and hold compare chain sets the cycle
// time. Configuration writes are always ready and take effect at once; write
// them only while no item is in flight. A write to register index 3 is ignored.
module button_debounce_hold_events_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bdhe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdhe_pkg::CNT_W-1:0]           cfg_data,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bdhe_pkg::FIELD_W-1:0]         raw_buttons,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bdhe_pkg::FIELD_W-1:0]         press_mask,
  output logic [bdhe_pkg::FIELD_W-1:0]         release_mask,
  output logic [bdhe_pkg::FIELD_W-1:0]         hold_instant_mask,
  output logic [bdhe_pkg::FIELD_W-1:0]         hold_continuous_mask,
  output logic [bdhe_pkg::FIELD_W-1:0]         clean_buttons,
  output logic [bdhe_pkg::CTRL_W-1:0]          control_index,
  output logic [bdhe_pkg::PRIOR_W-1:0]         prior_control_index,
  output logic [bdhe_pkg::TUNE_W-1:0]          tuning_index,
  output logic                                 tuning_changed,
  output logic                                 loading_flag,
  output logic signed [bdhe_pkg::BTN_W-1:0]    last_event_button,
  output logic [bdhe_pkg::KIND_W-1:0]          last_event_kind
);

  bdhe_pkg::cfg_t                  cfg;
  logic                            stage_valid;
  logic [bdhe_pkg::FIELD_W-1:0]    stage_raw;
  logic                            adv;
  bdhe_pkg::lane_evt_t             evt [bdhe_pkg::FIELD_W];
  bdhe_pkg::sel_stat_t             stat;
  bdhe_pkg::kind_t                 last_kind;
  logic [bdhe_pkg::FIELD_W-1:0]    press_vec;
  logic [bdhe_pkg::FIELD_W-1:0]    release_vec;
  logic [bdhe_pkg::FIELD_W-1:0]    inst_vec;
  logic [bdhe_pkg::FIELD_W-1:0]    cont_vec;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_threshold <= bdhe_pkg::CNT_W'(5);
      cfg.hold_threshold     <= bdhe_pkg::CNT_W'(200);
      cfg.hold_limit         <= bdhe_pkg::CNT_W'(200);
    end else if (cfg_valid) begin
      unique case (bdhe_pkg::cfg_idx_t'(cfg_index))
        bdhe_pkg::CFG_DEBOUNCE: cfg.debounce_threshold <= cfg_data;
        bdhe_pkg::CFG_HOLD_TH:  cfg.hold_threshold     <= cfg_data;
        bdhe_pkg::CFG_HOLD_LIM: cfg.hold_limit         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the held item when the result register is free or being taken
  assign adv      = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_raw <= raw_buttons;
    end
  end

  // Per-button lanes; field bits past the built buttons stay quiet
  for (genvar gi = 0; gi < bdhe_pkg::FIELD_W; gi++) begin : g_lane
    if (gi < bdhe_pkg::BUTTONS) begin : g_on
      bdhe_lane u_lane (
        .clk   (clk),
        .rst   (rst),
        .adv   (adv),
        .raw   (stage_raw[gi]),
        .cfg   (cfg),
        .evt   (evt[gi]),
        .clean (clean_buttons[gi])
      );
    end else begin : g_off
      assign evt[gi]           = '{press: 1'b0, release_ev: 1'b0, hold_inst: 1'b0,
                                   hold_cont: 1'b0, kind: bdhe_pkg::KIND_NONE};
      assign clean_buttons[gi] = 1'b0;
    end
    assign press_vec[gi]   = evt[gi].press;
    assign release_vec[gi] = evt[gi].release_ev;
    assign inst_vec[gi]    = evt[gi].hold_inst;
    assign cont_vec[gi]    = evt[gi].hold_cont;
  end

  // Selector state updates in the same cycle as the lanes. The clean levels
  // and the selector registers change only when a result loads, so they are
  // driven straight from the state registers.
  bdhe_select u_select (
    .clk                 (clk),
    .rst                 (rst),
    .adv                 (adv),
    .evt                 (evt),
    .control_index       (control_index),
    .prior_control_index (prior_control_index),
    .tuning_index        (tuning_index),
    .loading_flag        (loading_flag),
    .last_button         (last_event_button),
    .last_kind           (last_kind),
    .stat                (stat)
  );

  assign last_event_kind = last_kind;

  // Result register: drop all masks of a tick that changed the control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      press_mask           <= stat.clear ? '0 : press_vec;
      release_mask         <= stat.clear ? '0 : release_vec;
      hold_instant_mask    <= stat.clear ? '0 : inst_vec;
      hold_continuous_mask <= stat.clear ? '0 : cont_vec;
      tuning_changed       <= stat.tuned;
    end
  end

endmodule

// ----- bench/button_debounce_hold_events_top_tb.sv -----
// Self-checking testbench for the button debouncer with hold events and selectors.
`timescale 1ns / 1ps

module button_debounce_hold_events_top_tb;
  import bdhe_pkg::*;

  // Register index that the block decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One result item as the block reports it after one scan tick
  typedef struct packed {
    logic [FIELD_W-1:0]      press_bits;
    logic [FIELD_W-1:0]      release_bits;
    logic [FIELD_W-1:0]      hold_inst_bits;
    logic [FIELD_W-1:0]      hold_cont_bits;
    logic [FIELD_W-1:0]      clean_bits;
    logic [CTRL_W-1:0]       control;
    logic [PRIOR_W-1:0]      prior_control;
    logic [TUNE_W-1:0]       tuning;
    logic                    tuning_step;
    logic                    loading;
    logic signed [BTN_W-1:0] last_button;
    kind_t                   last_kind;
  } tick_result_t;

  // Directed stimulus: either a threshold load or a run of identical ticks,
  // optionally with the result typed in by hand
  typedef struct packed {
    logic               load_row;
    logic [CNT_W-1:0]   debounce;
    logic [CNT_W-1:0]   hold_th;
    logic [CNT_W-1:0]   hold_lim;
    logic [FIELD_W-1:0] raw;
    logic [3:0]         repeats;
    logic               typed;
    tick_result_t       want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [FIELD_W-1:0] raw_buttons;
  logic out_valid;
  logic out_ready;
  logic [FIELD_W-1:0] press_mask;
  logic [FIELD_W-1:0] release_mask;
  logic [FIELD_W-1:0] hold_instant_mask;
  logic [FIELD_W-1:0] hold_continuous_mask;
  logic [FIELD_W-1:0] clean_buttons;
  logic [CTRL_W-1:0] control_index;
  logic [PRIOR_W-1:0] prior_control_index;
  logic [TUNE_W-1:0] tuning_index;
  logic tuning_changed;
  logic loading_flag;
  logic signed [BTN_W-1:0] last_event_button;
  logic [KIND_W-1:0] last_event_kind;

  // Predicted copy of the thresholds and of the debouncer state
  logic [CNT_W-1:0] deb_thresh;
  logic [CNT_W-1:0] hold_thresh;
  logic [CNT_W-1:0] hold_sat;
  logic [FIELD_W-1:0] raw_ref;
  logic [FIELD_W-1:0] clean_lvl;
  logic [CNT_W-1:0] miss_cnt [BUTTONS];
  logic [CNT_W-1:0] hold_cnt [BUTTONS];
  logic [CTRL_W-1:0] cur_control;
  logic [PRIOR_W-1:0] prev_control;
  logic [TUNE_W-1:0] cur_tuning;
  logic loading_seen;
  logic signed [BTN_W-1:0] last_btn;
  kind_t last_kind;

  tick_result_t pending_ticks [$];
  dir_row_t directed_rows [20];
  int error_count = 0;
  int random_sent = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  button_debounce_hold_events_top uut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .raw_buttons          (raw_buttons),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .press_mask           (press_mask),
    .release_mask         (release_mask),
    .hold_instant_mask    (hold_instant_mask),
    .hold_continuous_mask (hold_continuous_mask),
    .clean_buttons        (clean_buttons),
    .control_index        (control_index),
    .prior_control_index  (prior_control_index),
    .tuning_index         (tuning_index),
    .tuning_changed       (tuning_changed),
    .loading_flag         (loading_flag),
    .last_event_button    (last_event_button),
    .last_event_kind      (last_event_kind)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the predicted debouncer by one scan tick and return its result.
  // Buttons are walked from 0 upward so the last recorded event wins.
  task automatic debounce_tick(input logic [FIELD_W-1:0] raw, output tick_result_t res);
    logic [FIELD_W-1:0] press_b;
    logic [FIELD_W-1:0] rel_b;
    logic [FIELD_W-1:0] inst_b;
    logic [FIELD_W-1:0] cont_b;
    logic started_on;
    logic cleared;
    logic tuned;
    press_b = '0;
    rel_b = '0;
    inst_b = '0;
    cont_b = '0;
    cleared = 1'b0;
    tuned = 1'b0;
    for (int b = 0; b < BUTTONS; b++) begin
      started_on = clean_lvl[b];
      // Mismatches accumulate whether or not they are consecutive
      if (raw[b] != raw_ref[b] && miss_cnt[b] != '1) miss_cnt[b]++;
      if (started_on) begin
        cont_b[b] = 1'b1;
        last_btn = BTN_W'(b);
        last_kind = KIND_HOLD_CONT;
      end
      if (miss_cnt[b] < deb_thresh) begin
        // A count left above a lowered limit neither climbs nor gets cut
        if (hold_cnt[b] < hold_sat) hold_cnt[b]++;
        if (hold_cnt[b] >= hold_thresh && started_on) begin
          inst_b[b] = 1'b1;
          last_btn = BTN_W'(b);
          last_kind = KIND_HOLD_INST;
        end
      end else begin
        clean_lvl[b] = raw[b];
        raw_ref[b] = raw[b];
        miss_cnt[b] = '0;
        hold_cnt[b] = '0;
        last_btn = BTN_W'(b);
        if (raw[b]) begin
          press_b[b] = 1'b1;
          last_kind = KIND_PRESS;
        end else begin
          rel_b[b] = 1'b1;
          last_kind = KIND_RELEASE;
        end
      end
    end
    // Previous-control wins over next-control; either wipes the tick's events
    if (press_b[KEY_PREV]) begin
      prev_control = PRIOR_W'(cur_control);
      cur_control = (cur_control == 0) ? CTRL_W'(CONTROLS - 1) : cur_control - 1'b1;
      cleared = 1'b1;
    end else if (press_b[KEY_NEXT]) begin
      prev_control = PRIOR_W'(cur_control);
      cur_control = (int'(cur_control) >= CONTROLS - 1) ? '0 : cur_control + 1'b1;
      cleared = 1'b1;
    end
    if (cleared) begin
      loading_seen = 1'b1;
      press_b = '0;
      rel_b = '0;
      inst_b = '0;
      cont_b = '0;
      last_btn = BTN_NONE;
      last_kind = KIND_NONE;
    end else begin
      if (press_b[KEY_A]) begin
        cur_tuning = (cur_tuning == 0) ? TUNE_W'(TUNINGS - 1) : cur_tuning - 1'b1;
        tuned = 1'b1;
      end
      if (press_b[KEY_B]) begin
        cur_tuning = TUNE_W'((int'(cur_tuning) + 1) % TUNINGS);
        tuned = 1'b1;
      end
    end
    res = '{press_b, rel_b, inst_b, cont_b, clean_lvl, cur_control, prev_control,
            cur_tuning, tuned, loading_seen, last_btn, last_kind};
  endtask

  // Offer one tick; valid stays up until the block takes it, then predict.
  task automatic send_tick(input logic [FIELD_W-1:0] raw, input logic typed,
                           input tick_result_t want);
    tick_result_t predicted;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_buttons <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    debounce_tick(raw, predicted);
    pending_ticks.push_back(typed ? want : predicted);
  endtask

  // Hold the input side until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load all thresholds on an idle block; the unused index gets noise
  task automatic load_thresholds(input logic [CNT_W-1:0] db, input logic [CNT_W-1:0] ht,
                                 input logic [CNT_W-1:0] hl);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CNT_W-1:0] val [4];
    idx = '{CFG_DEBOUNCE, CFG_UNUSED, CFG_HOLD_TH, CFG_HOLD_LIM};
    val = '{db, CNT_W'($urandom), ht, hl};
    drain_results();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        CFG_DEBOUNCE: deb_thresh = val[i];
        CFG_HOLD_TH:  hold_thresh = val[i];
        CFG_HOLD_LIM: hold_sat = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Random ticks shaped as steady levels held for a while, with bounce noise
  // on top; most level changes touch one button so presses really debounce.
  task automatic random_phase(input int n_items);
    logic [FIELD_W-1:0] level;
    logic [FIELD_W-1:0] raw;
    int span;
    int run_len;
    int left;
    level = clean_lvl;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(3) == 0) level = FIELD_W'($urandom);
      else level ^= FIELD_W'(1) << $urandom_range(BUTTONS - 1);
      // Now and then hold long enough to reach the hold threshold
      if ($urandom_range(7) == 0) span = int'(hold_thresh) + 8;
      else span = int'(deb_thresh) + 4;
      if (span > 300) span = 300;
      run_len = $urandom_range(1, span);
      for (int j = 0; j < run_len && left > 0; j++) begin
        raw = level;
        if ($urandom_range(5) == 0) raw ^= FIELD_W'(1) << $urandom_range(BUTTONS - 1);
        // Receiver busy first, then sender busy, then both running flat out
        if (random_sent < 517) begin
          send_gap_pct = 23;
          recv_stall_pct = 49;
        end else if (random_sent < 1034) begin
          send_gap_pct = 49;
          recv_stall_pct = 23;
        end else begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        send_tick(raw, 1'b0, '0);
        random_sent++;
        left--;
        if ($urandom_range(299) == 0) drain_results();
      end
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] expv,
                             input logic signed [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endtask

  // Result side: take results under random back-pressure and compare each
  // against the oldest prediction
  initial begin
    tick_result_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_ticks.size() == 0) begin
          $error("result item with no tick outstanding");
          error_count++;
        end else begin
          want = pending_ticks.pop_front();
          check_field("press_mask", want.press_bits, press_mask);
          check_field("release_mask", want.release_bits, release_mask);
          check_field("hold_instant_mask", want.hold_inst_bits, hold_instant_mask);
          check_field("hold_continuous_mask", want.hold_cont_bits, hold_continuous_mask);
          check_field("clean_buttons", want.clean_bits, clean_buttons);
          check_field("control_index", want.control, control_index);
          check_field("prior_control_index", want.prior_control, prior_control_index);
          check_field("tuning_index", want.tuning, tuning_index);
          check_field("tuning_changed", want.tuning_step, tuning_changed);
          check_field("loading_flag", want.loading, loading_flag);
          check_field("last_event_button", want.last_button, last_event_button);
          check_field("last_event_kind", want.last_kind, last_event_kind);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus: reset, directed table, then random phases over several settings
  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    raw_buttons <= '0;

    deb_thresh = CNT_W'(5);
    hold_thresh = CNT_W'(200);
    hold_sat = CNT_W'(200);
    raw_ref = '0;
    clean_lvl = '0;
    for (int b = 0; b < BUTTONS; b++) begin
      miss_cnt[b] = '0;
      hold_cnt[b] = '0;
    end
    cur_control = '0;
    prev_control = PRIOR_W'(CONTROLS);
    cur_tuning = '0;
    loading_seen = 1'b0;
    last_btn = BTN_NONE;
    last_kind = KIND_NONE;

    // Result field order: press, release, hold instant, hold continuous, clean,
    // control, prior control, tuning, tuning step, loading, last button, last kind
    directed_rows = '{
      // Fresh from reset: nothing debounced, no control chosen before
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h00, 4'd1, 1'b1,
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0, PRIOR_W'(CONTROLS), 4'd0,
          1'b0, 1'b0, BTN_NONE, KIND_NONE}},
      // All pressed once: a single mismatch is below the default threshold
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'hFF, 4'd1, 1'b1,
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0, PRIOR_W'(CONTROLS), 4'd0,
          1'b0, 1'b0, BTN_NONE, KIND_NONE}},
      // Zero thresholds: clean level follows raw on every tick
      '{1'b1, 16'd0, 16'd0, 16'd0, 8'h00, 4'd0, 1'b0, '0},
      // Press all: previous-control wraps down from 0 and wipes the events
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'hFF, 4'd1, 1'b1,
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, CTRL_W'(CONTROLS - 1), 5'd0, 4'd0,
          1'b0, 1'b1, BTN_NONE, KIND_NONE}},
      // Release all: continuous on every button, the top one released last
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h00, 4'd1, 1'b1,
        '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, CTRL_W'(CONTROLS - 1), 5'd0, 4'd0,
          1'b0, 1'b1, BTN_W'(BUTTONS - 1), KIND_RELEASE}},
      '{1'b1, 16'd1, 16'd2, 16'd3, 8'h00, 4'd0, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h04, 4'd1, 1'b0, '0},  // tuning down wraps
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h08, 4'd1, 1'b0, '0},  // tuning up wraps
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h00, 4'd1, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h0C, 4'd1, 1'b0, '0},  // both tuning keys
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h0C, 4'd3, 1'b0, '0},  // hold instant, limit
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h02, 4'd1, 1'b0, '0},  // next wraps up
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h00, 4'd1, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h03, 4'd1, 1'b0, '0},  // previous beats next
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h03, 4'd1, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h80, 4'd1, 1'b0, '0},  // releases never clear
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h70, 4'd1, 1'b0, '0},
      '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 4'd0, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'h55, 4'd2, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 8'hAA, 4'd1, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].load_row) begin
        load_thresholds(directed_rows[i].debounce, directed_rows[i].hold_th,
                        directed_rows[i].hold_lim);
      end else begin
        repeat (directed_rows[i].repeats)
          send_tick(directed_rows[i].raw, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Build tall hold counts, then cut the limit below them with a threshold
    // above it, then sweep the extremes and a few middle settings
    load_thresholds(16'd3, 16'd20, 16'hFFFF);
    random_phase(250);
    load_thresholds(16'd2, 16'd6, 16'd4);
    random_phase(200);
    load_thresholds(16'd0, 16'd0, 16'd0);
    random_phase(150);
    load_thresholds(16'd1, 16'd1, 16'd1);
    random_phase(150);
    load_thresholds(16'd5, 16'd200, 16'd200);
    random_phase(350);
    load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(40);
    load_thresholds(16'd4, 16'd10, 16'd30);
    random_phase(250);
    load_thresholds(16'd2, 16'hFFFF, 16'hFFFF);
    random_phase(160);

    // Drop valid, wait out the outstanding results and a few quiet cycles
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("button_debounce_hold_events_top_tb OK");
    end else begin
      $display("button_debounce_hold_events_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("button_debounce_hold_events_top_tb NOT OK");
    $finish;
  end

endmodule
